/* rtl/pkgate_pkg.sv */
package pkgate_pkg;

	localparam int unsigned WORK_DEPTH_DEF = 2;
	localparam int unsigned OUT_DEPTH_DEF  = 2;

	localparam int unsigned PORT_W = 16;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_FIRST   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SECOND  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_THIRD   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GUARD   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_EXEMPT  = 3'd5;

	localparam logic [PORT_W-1:0] FIRST_RST   = 16'd2345;
	localparam logic [PORT_W-1:0] SECOND_RST  = 16'd3456;
	localparam logic [PORT_W-1:0] THIRD_RST   = 16'd1233;
	localparam logic [PORT_W-1:0] GUARD_RST   = 16'd1234;
	localparam logic [PORT_W-1:0] TIMEOUT_RST = 16'(5 * 250);
	localparam logic [PORT_W-1:0] EXEMPT_RST  = 16'd22;

	// knock stages
	localparam logic [1:0] STG_IDLE = 2'd0;
	localparam logic [1:0] STG_ONE  = 2'd1;
	localparam logic [1:0] STG_TWO  = 2'd2;
	localparam logic [1:0] STG_OPEN = 2'd3;

	typedef enum logic [2:0] {
		CLS_FIRST,
		CLS_SECOND,
		CLS_THIRD,
		CLS_GUARD,
		CLS_EXEMPT,
		CLS_OTHER,
		CLS_NONTCP
	} cls_t;

	typedef struct packed {
		logic              is_tcp;
		logic [ADDR_W-1:0] source_address;
		logic [PORT_W-1:0] dest_port;
		logic              fin_flag;
		logic [TICK_W-1:0] now_ticks;
	} in_t;

	typedef struct packed {
		logic       drop;
		logic [1:0] stage_after;
	} out_t;

	typedef struct packed {
		cls_t              cls;
		logic [ADDR_W-1:0] source_address;
		logic              fin_flag;
		logic [TICK_W-1:0] now_ticks;
	} work_t;

	typedef struct packed {
		logic [PORT_W-1:0] first_knock_port;
		logic [PORT_W-1:0] second_knock_port;
		logic [PORT_W-1:0] third_knock_port;
		logic [PORT_W-1:0] guarded_port;
		logic [PORT_W-1:0] open_timeout;
		logic [PORT_W-1:0] exempt_port;
	} cfg_t;

endpackage

/* rtl/port_knock_gate_core.sv */
// Port-knocking gate. Each request is one packet summary; each result tells
// whether to drop it and the knock stage afterwards (3 = guarded port open).
// Throughput is one packet per clock while the result queue has room: the knock
// state in the back end is read and written back in the same cycle. A packet is
// classified by destination port as it is accepted into the classify queue; the
// back end judges it at the queue head and queues its result for output.
// Both the classify queue and the result queue let either side stall without
// stopping the other. Configuration registers reset to first/second/third
// knock 2345/3456/1233, guarded 1234, timeout 1250 ticks, exempt 22; write
// them only while no packet is in flight. Indexes past 5 are ignored.
module port_knock_gate_core import pkgate_pkg::*; #(
	parameter int unsigned WORK_DEPTH = WORK_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_t                  in_item,
	output logic                 empty,
	input  logic                 pop,
	output out_t                 out_item,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PORT_W-1:0]    cfg_data
);

	cfg_t  cfg_q;
	work_t work_in;
	work_t work_out;
	logic  work_empty;
	logic  work_pop;
	logic  out_full;
	logic  out_push;
	out_t  result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_knock_port  <= FIRST_RST;
			cfg_q.second_knock_port <= SECOND_RST;
			cfg_q.third_knock_port  <= THIRD_RST;
			cfg_q.guarded_port      <= GUARD_RST;
			cfg_q.open_timeout      <= TIMEOUT_RST;
			cfg_q.exempt_port       <= EXEMPT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST:   cfg_q.first_knock_port  <= cfg_data;
				REG_SECOND:  cfg_q.second_knock_port <= cfg_data;
				REG_THIRD:   cfg_q.third_knock_port  <= cfg_data;
				REG_GUARD:   cfg_q.guarded_port      <= cfg_data;
				REG_TIMEOUT: cfg_q.open_timeout      <= cfg_data;
				REG_EXEMPT:  cfg_q.exempt_port       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pkgate_front u_front (
		.cfg     (cfg_q),
		.in_item (in_item),
		.work    (work_in)
	);

	pkgate_fifo #(
		.WIDTH ($bits(work_t)),
		.DEPTH (WORK_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (work_in),
		.pop    (work_pop),
		.empty  (work_empty),
		.rdata  (work_out)
	);

	pkgate_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.work_empty (work_empty),
		.work       (work_out),
		.work_pop   (work_pop),
		.out_full   (out_full),
		.out_push   (out_push),
		.result     (result)
	);

	pkgate_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wdata  (result),
		.pop    (pop),
		.empty  (empty),
		.rdata  (out_item)
	);

endmodule

/* rtl/pkgate_fifo.sv */
module pkgate_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/pkgate_front.sv */
module pkgate_front import pkgate_pkg::*; (
	input  cfg_t  cfg,
	input  in_t   in_item,
	output work_t work
);

	// port match order: first, second, third, guarded, then exempt or other
	always_comb begin
		work.source_address = in_item.source_address;
		work.fin_flag       = in_item.fin_flag;
		work.now_ticks      = in_item.now_ticks;
		if (!in_item.is_tcp) begin
			work.cls = CLS_NONTCP;
		end else if (in_item.dest_port == cfg.first_knock_port) begin
			work.cls = CLS_FIRST;
		end else if (in_item.dest_port == cfg.second_knock_port) begin
			work.cls = CLS_SECOND;
		end else if (in_item.dest_port == cfg.third_knock_port) begin
			work.cls = CLS_THIRD;
		end else if (in_item.dest_port == cfg.guarded_port) begin
			work.cls = CLS_GUARD;
		end else if (in_item.dest_port == cfg.exempt_port) begin
			work.cls = CLS_EXEMPT;
		end else begin
			work.cls = CLS_OTHER;
		end
	end

endmodule

/* rtl/pkgate_back.sv */
module pkgate_back import pkgate_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  work_empty,
	input  work_t work,
	output logic  work_pop,
	input  logic  out_full,
	output logic  out_push,
	output out_t  result
);

	logic [1:0]        stage_q;
	logic [ADDR_W-1:0] knocker_q;
	logic [TICK_W-1:0] last_q;
	logic              closing_q;

	logic [1:0]        stage_n;
	logic [ADDR_W-1:0] knocker_n;
	logic [TICK_W-1:0] last_n;
	logic              closing_n;
	logic              drop;
	logic              mine;
	logic [TICK_W-1:0] diff;
	logic              expired;
	logic              take;

	assign take     = !work_empty && !out_full;
	assign work_pop = take;
	assign out_push = take;

	assign mine = (work.source_address == knocker_q);
	// wrap-aware: timed out when now lies past last + timeout
	assign diff    = last_q + TICK_W'(cfg.open_timeout) - work.now_ticks;
	assign expired = diff[TICK_W-1];

	always_comb begin
		stage_n   = stage_q;
		knocker_n = knocker_q;
		last_n    = last_q;
		closing_n = closing_q;
		drop      = 1'b0;
		case (work.cls)
			CLS_FIRST: begin
				knocker_n = work.source_address;
				stage_n   = STG_ONE;
			end
			CLS_SECOND: begin
				if (mine) begin
					stage_n = (stage_q == STG_ONE) ? STG_TWO : STG_IDLE;
				end
			end
			CLS_THIRD: begin
				if (mine) begin
					if (stage_q == STG_TWO) begin
						stage_n   = STG_OPEN;
						closing_n = 1'b0;
						last_n    = work.now_ticks;
					end else begin
						stage_n = STG_IDLE;
					end
				end
			end
			CLS_GUARD: begin
				drop = 1'b1;
				if (mine) begin
					if (closing_q) begin
						stage_n = STG_IDLE;
						drop    = 1'b0;
					end else if (stage_q == STG_OPEN) begin
						if (expired) begin
							stage_n = STG_IDLE;
						end else begin
							drop   = 1'b0;
							last_n = work.now_ticks;
							if (work.fin_flag) begin
								closing_n = 1'b1;
							end
						end
					end else begin
						stage_n = STG_IDLE;
					end
				end
			end
			CLS_OTHER: begin
				if (mine) begin
					stage_n = STG_IDLE;
				end
			end
			default: begin
			end
		endcase
		if (stage_n != STG_OPEN) begin
			closing_n = 1'b0;
		end
	end

	assign result.drop        = drop;
	assign result.stage_after = stage_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= STG_IDLE;
			knocker_q <= '0;
			last_q    <= '0;
			closing_q <= 1'b0;
		end else if (take) begin
			stage_q   <= stage_n;
			knocker_q <= knocker_n;
			last_q    <= last_n;
			closing_q <= closing_n;
		end
	end

	a_close_only_open: assert property (@(posedge clk) disable iff (!arst_n)
		closing_q |-> (stage_q == STG_OPEN))
		else $error("close pending outside open stage");

	a_first_knock: assert property (@(posedge clk) disable iff (!arst_n)
		(take && work.cls == CLS_FIRST) |=> (stage_q == STG_ONE))
		else $error("first knock did not enter stage one");

	a_result_stage: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (stage_q == $past(result.stage_after)))
		else $error("reported stage differs from stored stage");

	a_nontcp_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(take && work.cls == CLS_NONTCP) |=> ($stable(stage_q) && $stable(knocker_q)
			&& $stable(last_q)))
		else $error("non-TCP request changed knock state");

endmodule

/* dv/port_knock_gate_checker.sv */
module port_knock_gate_checker import pkgate_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  in_t                  in_item,
	input  logic                 empty,
	input  logic                 pop,
	input  out_t                 out_item,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PORT_W-1:0]    cfg_data,
	output int                   fails,
	output int                   pending,
	output int                   results,
	output int                   drops
);

	cfg_t              shadow;
	logic [1:0]        gate_stage;
	logic [ADDR_W-1:0] knocker;
	logic [TICK_W-1:0] last_tick;
	logic              close_armed;
	out_t              verdict_q [$];

	function automatic void set_stage(input logic [1:0] s);
		gate_stage = s;
		if (s != STG_OPEN)
			close_armed = 1'b0;
	endfunction

	// wrap-aware: lapsed when now lies past last_tick + timeout
	function automatic logic window_lapsed(input logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] d;
		d = last_tick + TICK_W'(shadow.open_timeout) - now;
		return d[TICK_W-1];
	endfunction

	function automatic out_t judge_packet(input in_t p);
		out_t r;
		logic mine;
		r.drop = 1'b0;
		mine = (p.source_address == knocker);
		if (p.is_tcp) begin
			// port order decides when registers overlap
			if (p.dest_port == shadow.first_knock_port) begin
				knocker = p.source_address;
				set_stage(STG_ONE);
			end else if (p.dest_port == shadow.second_knock_port) begin
				if (mine)
					set_stage(gate_stage == STG_ONE ? STG_TWO : STG_IDLE);
			end else if (p.dest_port == shadow.third_knock_port) begin
				if (mine) begin
					if (gate_stage == STG_TWO) begin
						set_stage(STG_OPEN);
						close_armed = 1'b0;
						last_tick = p.now_ticks;
					end else begin
						set_stage(STG_IDLE);
					end
				end
			end else if (p.dest_port == shadow.guarded_port) begin
				r.drop = 1'b1;
				if (mine) begin
					if (close_armed) begin
						set_stage(STG_IDLE);
						r.drop = 1'b0;
					end else if (gate_stage == STG_OPEN) begin
						if (window_lapsed(p.now_ticks)) begin
							set_stage(STG_IDLE);
						end else begin
							last_tick = p.now_ticks;
							if (p.fin_flag)
								close_armed = 1'b1;
							r.drop = 1'b0;
						end
					end else begin
						set_stage(STG_IDLE);
					end
				end
			end else if (mine && p.dest_port != shadow.exempt_port) begin
				set_stage(STG_IDLE);
			end
		end
		r.stage_after = gate_stage;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			shadow.first_knock_port  = FIRST_RST;
			shadow.second_knock_port = SECOND_RST;
			shadow.third_knock_port  = THIRD_RST;
			shadow.guarded_port      = GUARD_RST;
			shadow.open_timeout      = TIMEOUT_RST;
			shadow.exempt_port       = EXEMPT_RST;
			gate_stage  = STG_IDLE;
			knocker     = '0;
			last_tick   = '0;
			close_armed = 1'b0;
			verdict_q.delete();
			fails   = 0;
			pending = 0;
			results = 0;
			drops   = 0;
		end else begin
			if (pop && !empty) begin
				results++;
				if (out_item.drop)
					drops++;
				if (verdict_q.size() == 0) begin
					fails++;
					$display("%0t: result with no request waiting: drop=%0d stage=%0d",
						$time, out_item.drop, out_item.stage_after);
				end else begin
					want = verdict_q.pop_front();
					if (out_item.drop !== want.drop) begin
						fails++;
						$display("%0t: drop mismatch: expected %0d, got %0d",
							$time, want.drop, out_item.drop);
					end
					if (out_item.stage_after !== want.stage_after) begin
						fails++;
						$display("%0t: stage_after mismatch: expected %0d, got %0d",
							$time, want.stage_after, out_item.stage_after);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST:   shadow.first_knock_port  = cfg_data;
					REG_SECOND:  shadow.second_knock_port = cfg_data;
					REG_THIRD:   shadow.third_knock_port  = cfg_data;
					REG_GUARD:   shadow.guarded_port      = cfg_data;
					REG_TIMEOUT: shadow.open_timeout      = cfg_data;
					REG_EXEMPT:  shadow.exempt_port       = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				verdict_q.push_back(judge_packet(in_item));
			pending = verdict_q.size();
		end
	end

endmodule

/* dv/port_knock_gate_core_tb.sv */
module port_knock_gate_core_tb;
	import pkgate_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 190;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_EXEMPT + 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_EXEMPT + 3'd2;

	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_t                  in_item;
	logic                 empty;
	logic                 pop = 1'b0;
	out_t                 out_item;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [PORT_W-1:0]    cfg_data;

	int fails, pending, results, drops;
	int sent = 0;
	int settings = 1;
	int cycle_count = 0;
	int burst_left = 0;
	int rx_left = 0;
	rx_mode_t rx_mode = RX_STREAM;

	cfg_t              cur;
	logic [TICK_W-1:0] now_tick;
	logic [ADDR_W-1:0] src_pool [4];

	port_knock_gate_core dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	port_knock_gate_checker gate_watch (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .results(results), .drops(drops)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("port_knock_gate_core verification failed");
			$finish;
		end
	end

	// result side: stretches of steady popping, coin flips, sparse pops and holds
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(5, 60);
			end
			rx_left--;
			case (rx_mode)
				RX_STREAM: pop <= 1'b1;
				RX_COIN:   pop <= 1'($urandom_range(0, 1));
				RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
				RX_HOLD:   pop <= 1'b0;
			endcase
		end
	end

	function automatic in_t pkt(input logic tcp, input logic [ADDR_W-1:0] src,
			input logic [PORT_W-1:0] port, input logic fin, input logic [TICK_W-1:0] now);
		in_t p;
		p.is_tcp         = tcp;
		p.source_address = src;
		p.dest_port      = port;
		p.fin_flag       = fin;
		p.now_ticks      = now;
		return p;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_src();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return src_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [PORT_W-1:0] any_port();
		case ($urandom_range(0, 8))
			0: return cur.first_knock_port;
			1: return cur.second_knock_port;
			2: return cur.third_knock_port;
			3: return cur.guarded_port;
			4: return cur.exempt_port;
			5: return $urandom_range(0, 1) ? '1 : '0;
			default: return PORT_W'($urandom);
		endcase
	endfunction

	// mostly inside the open window, some at or just past its edge, a few anywhere
	function automatic logic [TICK_W-1:0] tick_step();
		logic [TICK_W-1:0] lim;
		lim = TICK_W'(cur.open_timeout);
		case ($urandom_range(0, 9))
			7: return lim + TICK_W'($urandom_range(1, 50));
			8: return lim + TICK_W'($urandom_range(0, 1));
			9: return $urandom;
			default: return TICK_W'($urandom_range(0, lim));
		endcase
	endfunction

	function automatic cfg_t rand_cfg(input int tmax);
		cfg_t c;
		c.first_knock_port  = PORT_W'($urandom);
		c.second_knock_port = PORT_W'($urandom);
		c.third_knock_port  = PORT_W'($urandom);
		c.guarded_port      = PORT_W'($urandom);
		c.open_timeout      = PORT_W'($urandom_range(0, tmax));
		c.exempt_port       = PORT_W'($urandom);
		return c;
	endfunction

	// ports drawn from three values so the priority order gets exercised
	function automatic cfg_t overlap_cfg();
		cfg_t c;
		logic [PORT_W-1:0] few [3];
		few[0] = PORT_W'($urandom);
		few[1] = PORT_W'($urandom);
		few[2] = PORT_W'($urandom);
		c.first_knock_port  = few[$urandom_range(0, 2)];
		c.second_knock_port = few[$urandom_range(0, 2)];
		c.third_knock_port  = few[$urandom_range(0, 2)];
		c.guarded_port      = few[$urandom_range(0, 2)];
		c.open_timeout      = PORT_W'($urandom_range(0, 2000));
		c.exempt_port       = few[$urandom_range(0, 2)];
		return c;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_pkt(input in_t p);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
			end
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_item <= p;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_cfg(input cfg_t c, input bit spare);
		logic [PORT_W-1:0] vals [6];
		vals[0] = c.first_knock_port;
		vals[1] = c.second_knock_port;
		vals[2] = c.third_knock_port;
		vals[3] = c.guarded_port;
		vals[4] = c.open_timeout;
		vals[5] = c.exempt_port;
		settle();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_FIRST + REG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(negedge clk);
		end
		// indexes past the register file must be ignored
		if (spare) begin
			cfg_index <= REG_SPARE_LO;
			cfg_data  <= PORT_W'($urandom);
			@(negedge clk);
			cfg_index <= REG_SPARE_HI;
			cfg_data  <= PORT_W'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cur = c;
		settings++;
	endtask

	task automatic knock(input logic [ADDR_W-1:0] src, input logic [PORT_W-1:0] port);
		send_pkt(pkt(1'b1, src, port, 1'($urandom_range(0, 1)), now_tick));
		now_tick += TICK_W'($urandom_range(0, 40));
	endtask

	task automatic maybe_noise(input logic [ADDR_W-1:0] who);
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 2))
				0: send_pkt(pkt(1'b0, who, any_port(), 1'($urandom_range(0, 1)), now_tick));
				1: send_pkt(pkt(1'b1, who, cur.exempt_port, 1'($urandom_range(0, 1)), now_tick));
				default: send_pkt(pkt(1'b1, pick_src(), any_port(),
					1'($urandom_range(0, 1)), now_tick));
			endcase
		end
	endtask

	task automatic directed();
		logic [ADDR_W-1:0] a, b, ones;
		logic [TICK_W-1:0] t;
		a    = 32'h0A00_0001;
		b    = 32'hC0A8_0105;
		ones = '1;
		t    = 32'hFFFF_FF00;
		send_pkt(pkt(1'b0, '0, cur.guarded_port, 1'b1, '0));
		// knocker address is zero out of reset
		send_pkt(pkt(1'b1, '0, cur.guarded_port, 1'b0, '0));
		send_pkt(pkt(1'b1, a, cur.first_knock_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.exempt_port, 1'b0, t));
		send_pkt(pkt(1'b1, b, cur.second_knock_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.second_knock_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.third_knock_port, 1'b0, t));
		// time wraps through zero while the window is still open
		t += 32'h200;
		send_pkt(pkt(1'b1, a, cur.guarded_port, 1'b0, t));
		send_pkt(pkt(1'b1, b, cur.guarded_port, 1'b0, t));
		t += TICK_W'(cur.open_timeout);
		send_pkt(pkt(1'b1, a, cur.guarded_port, 1'b1, t));
		send_pkt(pkt(1'b1, a, cur.exempt_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.guarded_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.guarded_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.first_knock_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.second_knock_port, 1'b0, t));
		send_pkt(pkt(1'b1, a, cur.third_knock_port, 1'b0, t));
		// one tick past the window
		t += TICK_W'(cur.open_timeout) + 1;
		send_pkt(pkt(1'b1, a, cur.guarded_port, 1'b0, t));
		send_pkt(pkt(1'b1, ones, cur.first_knock_port, 1'b1, ones));
		send_pkt(pkt(1'b1, ones, '1, 1'b1, ones));
		send_pkt(pkt(1'b1, ones, cur.first_knock_port, 1'b0, ones));
		send_pkt(pkt(1'b1, ones, cur.third_knock_port, 1'b0, ones));
		send_pkt(pkt(1'b1, ones, '0, 1'b0, '0));
		send_pkt(pkt(1'b0, ones, '1, 1'b1, ones));
		send_pkt(pkt(1'b1, ones, cur.second_knock_port, 1'b0, '0));
	endtask

	task automatic run_phase(input int n);
		int stop;
		int k;
		logic [ADDR_W-1:0] who;
		stop = sent + n;
		src_pool[0] = '0;
		src_pool[1] = '1;
		src_pool[2] = $urandom;
		src_pool[3] = $urandom;
		now_tick = $urandom;
		while (sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// complete sequence with random traffic mixed in
					who = pick_src();
					knock(who, cur.first_knock_port);
					maybe_noise(who);
					knock(who, cur.second_knock_port);
					maybe_noise(who);
					knock(who, cur.third_knock_port);
					k = $urandom_range(1, 8);
					repeat (k) begin
						maybe_noise(who);
						now_tick += tick_step();
						send_pkt(pkt(1'b1, who, cur.guarded_port,
							($urandom_range(0, 4) == 0), now_tick));
					end
				end
				6, 7: begin
					who = pick_src();
					k = $urandom_range(2, 6);
					repeat (k) begin
						if ($urandom_range(0, 3) == 0)
							now_tick += tick_step();
						knock(who, any_port());
					end
				end
				default: begin
					now_tick += TICK_W'($urandom_range(0, 100));
					send_pkt(pkt(1'($urandom_range(0, 1)), pick_src(), any_port(),
						1'($urandom_range(0, 1)), now_tick));
				end
			endcase
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		push      = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		cur.first_knock_port  = FIRST_RST;
		cur.second_knock_port = SECOND_RST;
		cur.third_knock_port  = THIRD_RST;
		cur.guarded_port      = GUARD_RST;
		cur.open_timeout      = TIMEOUT_RST;
		cur.exempt_port       = EXEMPT_RST;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed();

		load_cfg(rand_cfg(3000), 1'b0);
		run_phase(PHASE_ITEMS);

		c.first_knock_port  = 16'd0;
		c.second_knock_port = 16'd1;
		c.third_knock_port  = 16'd2;
		c.guarded_port      = 16'd3;
		c.open_timeout      = 16'd0;
		c.exempt_port       = 16'd4;
		load_cfg(c, 1'b0);
		run_phase(PHASE_ITEMS);

		c.first_knock_port  = 16'hFFFF;
		c.second_knock_port = 16'hFFFE;
		c.third_knock_port  = 16'hFFFD;
		c.guarded_port      = 16'hFFFC;
		c.open_timeout      = 16'hFFFF;
		c.exempt_port       = 16'hFFFB;
		load_cfg(c, 1'b1);
		run_phase(PHASE_ITEMS);

		load_cfg(overlap_cfg(), 1'b0);
		run_phase(PHASE_ITEMS);

		c.first_knock_port  = FIRST_RST;
		c.second_knock_port = SECOND_RST;
		c.third_knock_port  = THIRD_RST;
		c.guarded_port      = GUARD_RST;
		c.open_timeout      = TIMEOUT_RST;
		c.exempt_port       = EXEMPT_RST;
		load_cfg(c, 1'b1);
		run_phase(PHASE_ITEMS);

		load_cfg(rand_cfg(65535), 1'b0);
		run_phase(PHASE_ITEMS);

		load_cfg(rand_cfg(500), 1'b0);
		run_phase(PHASE_ITEMS);

		settle();
		repeat (4) @(negedge clk);

		$display("%0d packets sent under %0d register settings", sent, settings);
		$display("%0d results checked, %0d of them drops", results, drops);
		if (fails == 0 && pending == 0) begin
			$display("port_knock_gate_core verification clean");
		end else begin
			$display("port_knock_gate_core verification failed");
		end
		$finish;
	end

endmodule
